// File: rtl/lpw_pkg.sv
// shared types, constants and helpers for the line pixel walker
package lpw_pkg;

    localparam int COORD_BITS  = 16;
    localparam int CANVAS_BITS = 15;
    localparam int COLOR_BITS  = 32;
    localparam int DELTA_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int CMP_BITS    = (COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = CANVAS_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT = 1'd1;

    localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RST  = 15'd640;
    localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RST = 15'd480;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        MODE_DIAG   = 2'd0,
        MODE_XMAJOR = 2'd1,
        MODE_YMAJOR = 2'd2
    } line_mode_t;

    typedef struct packed
    {
        op_t                           opcode;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic [COLOR_BITS-1:0]         line_color;
    } lpw_in_t;

    typedef struct packed
    {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic [COLOR_BITS-1:0]         pixel_color;
        logic                          inside_res;
        logic                          last;
    } lpw_out_t;

    typedef struct packed
    {
        logic [CANVAS_BITS-1:0] width;
        logic [CANVAS_BITS-1:0] height;
    } lpw_canvas_t;

    function automatic logic in_range(logic signed [COORD_BITS-1:0] v,
                                      logic [CANVAS_BITS-1:0] lim);
        logic [COORD_BITS-1:0] u;
        u = unsigned'(v);
        return !v[COORD_BITS-1] && (CMP_BITS'(u) < CMP_BITS'(lim));
    endfunction

endpackage

// File: rtl/line_pixel_walker_top.sv
// line pixel walker top level: input register, walker, result register
// One word is taken per clock and one pixel word is produced per clock while
// the result register is not stalled. A load word gives the first pixel of a
// line, each step word the next pixel; a step word with no line in progress
// gives nothing. A word is held in the input register; when it fires, the
// walker updates the line state and the error term, and the pixel is written
// into the result register, where out_valid rises. in_ready follows
// out_ready through the single input register: the block stalls only while the
// result register holds a word that is not being taken. Canvas registers may be
// written at any time the block is idle.
module line_pixel_walker_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lpw_pkg::lpw_in_t                   in_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lpw_pkg::lpw_out_t                  out_word,
    input  logic                               cfg_we,
    input  logic [lpw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lpw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lpw_pkg::*;

    logic        in_valid_reg, in_valid_next;
    lpw_in_t     in_word_reg, in_word_next;
    logic        out_valid_reg, out_valid_next;
    lpw_out_t    out_word_reg, out_word_next;
    logic        fire;
    logic        res_valid;
    lpw_out_t    res;
    lpw_canvas_t canvas;

    lpw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .canvas    (canvas)
    );

    lpw_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_word_reg),
        .canvas    (canvas),
        .res_valid (res_valid),
        .res       (res)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_word_next   = in_word_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (fire)
            in_valid_next = 1'b0;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            in_word_next  = in_word;
        end
        if (fire)
        begin
            out_valid_next = res_valid;
            out_word_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// File: rtl/lpw_cfg_regs.sv
// canvas size configuration registers
module lpw_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lpw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [lpw_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output lpw_pkg::lpw_canvas_t                 canvas
);
    import lpw_pkg::*;

    logic [CANVAS_BITS-1:0] width_reg;
    logic [CANVAS_BITS-1:0] width_next;
    logic [CANVAS_BITS-1:0] height_reg;
    logic [CANVAS_BITS-1:0] height_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CANVAS_WIDTH:  width_next  = cfg_data;
                REG_CANVAS_HEIGHT: height_next = cfg_data;
                default:
                begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CANVAS_WIDTH_RST;
            height_reg <= CANVAS_HEIGHT_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign canvas.width  = width_reg;
    assign canvas.height = height_reg;

endmodule

// File: rtl/lpw_walker.sv
// line state and combinational pixel step with incremental error term
module lpw_walker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  lpw_pkg::lpw_in_t     item,
    input  lpw_pkg::lpw_canvas_t canvas,
    output logic                 res_valid,
    output lpw_pkg::lpw_out_t    res
);
    import lpw_pkg::*;

    logic                          active_reg, active_next;
    logic signed [COORD_BITS-1:0]  cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0]  cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0]  dest_x_reg, dest_x_next;
    logic signed [COORD_BITS-1:0]  dest_y_reg, dest_y_next;
    line_mode_t                    mode_reg, mode_next;
    logic                          neg_x_reg, neg_x_next;
    logic                          neg_y_reg, neg_y_next;
    logic signed [ERR_BITS-1:0]    inc_reg, inc_next;
    logic signed [ERR_BITS-1:0]    dec_reg, dec_next;
    logic signed [ERR_BITS-1:0]    err_reg, err_next;
    logic [COLOR_BITS-1:0]         color_reg, color_next;

    // load-side setup
    logic signed [DELTA_BITS-1:0]  dx, dy;
    logic [DELTA_BITS-1:0]         adx, ady;
    logic signed [ERR_BITS-1:0]    dx_e, dy_e;
    logic                          ld_neg_x, ld_neg_y;
    line_mode_t                    ld_mode;
    logic signed [ERR_BITS-1:0]    ld_inc, ld_dec;
    logic                          ld_last;

    // step-side datapath
    logic signed [COORD_BITS-1:0]  step_x, step_y;
    logic signed [ERR_BITS-1:0]    err_maj, err_min;
    logic [ERR_BITS-1:0]           mag_maj, mag_min;
    logic                          take_minor;

    logic signed [COORD_BITS-1:0]  px, py;
    logic                          plast;

    assign dx = {item.end_x[COORD_BITS-1], item.end_x}
              - {item.start_x[COORD_BITS-1], item.start_x};
    assign dy = {item.end_y[COORD_BITS-1], item.end_y}
              - {item.start_y[COORD_BITS-1], item.start_y};
    assign adx = dx[DELTA_BITS-1] ? unsigned'(-dx) : unsigned'(dx);
    assign ady = dy[DELTA_BITS-1] ? unsigned'(-dy) : unsigned'(dy);
    assign dx_e = ERR_BITS'(dx);
    assign dy_e = ERR_BITS'(dy);
    assign ld_neg_x = dx[DELTA_BITS-1] || (dx == '0);
    assign ld_neg_y = dy[DELTA_BITS-1] || (dy == '0);
    assign ld_last  = (item.start_x == item.end_x) && (item.start_y == item.end_y);

    always_comb
    begin
        if (adx == ady)
            ld_mode = MODE_DIAG;
        else if (ady < adx)
            ld_mode = MODE_XMAJOR;
        else
            ld_mode = MODE_YMAJOR;
    end

    // inc is added to the error on every major step, dec is also subtracted on a minor step
    always_comb
    begin
        case (ld_mode)
            MODE_XMAJOR:
            begin
                ld_inc = ld_neg_x ? -dy_e : dy_e;
                ld_dec = ld_neg_y ? -dx_e : dx_e;
            end
            MODE_YMAJOR:
            begin
                ld_inc = ld_neg_y ? -dx_e : dx_e;
                ld_dec = ld_neg_x ? -dy_e : dy_e;
            end
            default:
            begin
                ld_inc = '0;
                ld_dec = '0;
            end
        endcase
    end

    assign step_x = cur_x_reg + (neg_x_reg ? '1 : COORD_BITS'(1));
    assign step_y = cur_y_reg + (neg_y_reg ? '1 : COORD_BITS'(1));
    assign err_maj = err_reg + inc_reg;
    assign err_min = err_maj - dec_reg;
    assign mag_maj = err_maj[ERR_BITS-1] ? unsigned'(-err_maj) : unsigned'(err_maj);
    assign mag_min = err_min[ERR_BITS-1] ? unsigned'(-err_min) : unsigned'(err_min);
    assign take_minor = mag_min < mag_maj;

    always_comb
    begin
        active_next = active_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        dest_x_next = dest_x_reg;
        dest_y_next = dest_y_reg;
        mode_next   = mode_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        inc_next    = inc_reg;
        dec_next    = dec_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        res_valid   = 1'b0;
        px          = cur_x_reg;
        py          = cur_y_reg;
        plast       = 1'b0;
        case (item.opcode)
            OP_LOAD:
            begin
                res_valid = 1'b1;
                px        = item.start_x;
                py        = item.start_y;
                plast     = ld_last;
                if (fire)
                begin
                    active_next = !ld_last;
                    cur_x_next  = item.start_x;
                    cur_y_next  = item.start_y;
                    dest_x_next = item.end_x;
                    dest_y_next = item.end_y;
                    mode_next   = ld_mode;
                    neg_x_next  = ld_neg_x;
                    neg_y_next  = ld_neg_y;
                    inc_next    = ld_inc;
                    dec_next    = ld_dec;
                    err_next    = '0;
                    color_next  = item.line_color;
                end
            end
            OP_STEP:
            begin
                res_valid = active_reg;
                case (mode_reg)
                    MODE_XMAJOR:
                    begin
                        px    = step_x;
                        py    = take_minor ? step_y : cur_y_reg;
                        plast = (step_x == dest_x_reg);
                    end
                    MODE_YMAJOR:
                    begin
                        px    = take_minor ? step_x : cur_x_reg;
                        py    = step_y;
                        plast = (step_y == dest_y_reg);
                    end
                    default:
                    begin
                        px    = step_x;
                        py    = step_y;
                        plast = (step_x == dest_x_reg);
                    end
                endcase
                if (fire && active_reg)
                begin
                    cur_x_next  = px;
                    cur_y_next  = py;
                    err_next    = take_minor ? err_min : err_maj;
                    active_next = !plast;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            dest_x_reg <= '0;
            dest_y_reg <= '0;
            mode_reg   <= MODE_DIAG;
            neg_x_reg  <= 1'b0;
            neg_y_reg  <= 1'b0;
            inc_reg    <= '0;
            dec_reg    <= '0;
            err_reg    <= '0;
            color_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            dest_x_reg <= dest_x_next;
            dest_y_reg <= dest_y_next;
            mode_reg   <= mode_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
            inc_reg    <= inc_next;
            dec_reg    <= dec_next;
            err_reg    <= err_next;
            color_reg  <= color_next;
        end
    end

    always_comb
    begin
        res.pixel_x     = px;
        res.pixel_y     = py;
        res.pixel_color = (item.opcode == OP_LOAD) ? item.line_color : color_reg;
        res.inside_res  = in_range(px, canvas.width) && in_range(py, canvas.height);
        res.last        = plast;
    end

endmodule

// File: rtl/lpw_checker.sv
// port-level checks for the line pixel walker, bound to the top level
module lpw_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input lpw_pkg::lpw_out_t out_word
);
    import lpw_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // an empty result register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // a pixel flagged inside has nonnegative coordinates
    a_inside_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.inside_res |->
            !out_word.pixel_x[COORD_BITS-1] && !out_word.pixel_y[COORD_BITS-1])
        else $error("negative pixel flagged inside");

    // nothing is shown when reset is released
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind line_pixel_walker_top lpw_checker u_lpw_checker (.*);
